/* rtl/sqw_pkg.sv */
// Shared types and constants for the square wave sound channel.
// No dependencies; imported by every module.
`timescale 1ns / 1ps
package sqw_pkg;

  // Operation carried by each input item
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_LEN_STEP = 3'd1,
    OP_ENV_STEP = 3'd2,
    OP_WRITE    = 3'd3,
    OP_READ     = 3'd4,
    OP_POWER    = 3'd5
  } op_e;

  // Register addresses
  localparam logic [15:0] ADDR_DUTY_LEN = 16'hFF16;
  localparam logic [15:0] ADDR_ENVELOPE = 16'hFF17;
  localparam logic [15:0] ADDR_FREQ_LO  = 16'hFF18;
  localparam logic [15:0] ADDR_FREQ_HI  = 16'hFF19;

  // Read values and field constants
  localparam logic [7:0] READ_OPEN    = 8'hFF;
  localparam logic [5:0] READ_LOW_SET = 6'h3F;
  localparam logic [6:0] LEN_FULL     = 7'd64;
  localparam logic [6:0] LEN_FULL_M1  = 7'd63;
  localparam logic [3:0] ENV_DEFAULT  = 4'd8;
  localparam logic [3:0] VOL_MAX      = 4'd15;

  // Input item payload
  typedef struct packed {
    op_e         opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        frame_phase_odd;
    logic        power_init_length;
  } item_t;

  // Result item payload
  typedef struct packed {
    logic [3:0] sample_out;
    logic [7:0] read_data;
    logic       channel_on;
  } result_t;

endpackage

/* rtl/sqw_item_if.sv */
// Input item channel: valid/ready handshake with the operation fields.
// Standalone; no package dependency.
`timescale 1ns / 1ps
interface sqw_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        frame_phase_odd;
  logic        power_init_length;

  modport source (
    output valid, opcode, address, write_data, frame_phase_odd, power_init_length,
    input  ready
  );
  modport sink (
    input  valid, opcode, address, write_data, frame_phase_odd, power_init_length,
    output ready
  );
endinterface

/* rtl/sqw_result_if.sv */
// Result item channel: valid/ready handshake with sample, read data and status.
// Standalone; no package dependency.
`timescale 1ns / 1ps
interface sqw_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] sample_out;
  logic [7:0] read_data;
  logic       channel_on;

  modport source (
    output valid, sample_out, read_data, channel_on,
    input  ready
  );
  modport sink (
    input  valid, sample_out, read_data, channel_on,
    output ready
  );
endinterface

/* rtl/sqw_chan.sv */
// Channel state and its single-pass update for one registered item.
// Depends on sqw_pkg for the item, result and opcode types.
`timescale 1ns / 1ps
module sqw_chan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  sqw_pkg::item_t   item_i,
  output sqw_pkg::result_t res_o
);
  import sqw_pkg::*;

  typedef struct packed {
    logic        enable_flag;
    logic [1:0]  duty_select;
    logic        length_enable;
    logic [6:0]  length_count;
    logic [3:0]  env_start_volume;
    logic        env_up;
    logic [2:0]  env_period;
    logic [3:0]  env_count;
    logic [10:0] period_value;
    logic [12:0] period_count;
    logic [2:0]  duty_phase;
    logic        duty_level;
    logic [3:0]  current_volume;
    logic [3:0]  last_sample;
  } chan_state_t;

  chan_state_t st_q, st_d;
  logic [12:0] pc_dec;
  logic [3:0]  ec_dec;
  logic [7:0]  rd;
  logic [7:0]  wd;
  logic        len_bit;

  // Reload is (2048 - f) * 4 kept to 13 bits, i.e. the 11-bit negation shifted
  function automatic logic [12:0] reload_f(logic [10:0] pv);
    logic [10:0] neg;
    neg = 11'd0 - pv;
    return {neg, 2'b00};
  endfunction

  // Waveform level for a duty setting and phase
  function automatic logic duty_level_f(logic [1:0] sel, logic [2:0] ph);
    logic lvl;
    unique case (sel)
      2'd0: lvl = (ph == 3'd6);
      2'd1: lvl = (ph >= 3'd6);
      2'd2: lvl = (ph >= 3'd4);
      default: lvl = (ph <= 3'd5);
    endcase
    return lvl;
  endfunction

  // Decrement the length counter unless already zero; disable on reaching zero
  function automatic chan_state_t length_step_f(chan_state_t s);
    chan_state_t r;
    r = s;
    if (s.length_count != '0) begin
      r.length_count = s.length_count - 7'd1;
      if (r.length_count == '0) begin
        r.enable_flag = 1'b0;
      end
    end
    return r;
  endfunction

  // Next state and result for the item in the input register
  always_comb begin
    st_d    = st_q;
    rd      = READ_OPEN;
    wd      = item_i.write_data;
    len_bit = wd[6];
    pc_dec  = st_q.period_count - 13'd1;
    ec_dec  = st_q.env_count - 4'd1;
    unique case (item_i.opcode)
      OP_TICK: begin
        if (pc_dec == '0) begin
          st_d.period_count = reload_f(st_q.period_value);
          st_d.duty_phase   = st_q.duty_phase + 3'd1;
          st_d.duty_level   = duty_level_f(st_q.duty_select, st_d.duty_phase);
        end else begin
          st_d.period_count = pc_dec;
        end
        st_d.last_sample = (st_q.enable_flag && st_d.duty_level) ?
                           st_q.current_volume : 4'd0;
      end
      OP_LEN_STEP: begin
        if (st_q.length_enable) begin
          st_d = length_step_f(st_q);
        end
      end
      OP_ENV_STEP: begin
        if (st_q.enable_flag && st_q.env_period != '0) begin
          st_d.env_count = ec_dec;
          if (ec_dec == '0) begin
            st_d.env_count = {1'b0, st_q.env_period};
            if (!st_q.env_up && st_q.current_volume != '0) begin
              st_d.current_volume = st_q.current_volume - 4'd1;
            end
            if (st_q.env_up && st_q.current_volume != VOL_MAX) begin
              st_d.current_volume = st_q.current_volume + 4'd1;
            end
          end
        end
      end
      OP_WRITE: begin
        priority if (item_i.address == ADDR_DUTY_LEN) begin
          st_d.duty_select  = wd[7:6];
          st_d.length_count = LEN_FULL - {1'b0, wd[5:0]};
        end else if (item_i.address == ADDR_ENVELOPE) begin
          st_d.env_start_volume = wd[7:4];
          st_d.env_up           = wd[3];
          st_d.env_period       = wd[2:0];
          if (wd[7:4] == '0 && !wd[3]) begin
            st_d.enable_flag = 1'b0;
          end
        end else if (item_i.address == ADDR_FREQ_LO) begin
          st_d.period_value[7:0] = wd;
        end else if (item_i.address == ADDR_FREQ_HI) begin
          // Length enable rising on an odd frame phase clocks length once
          if (item_i.frame_phase_odd && !st_q.length_enable && len_bit) begin
            st_d = length_step_f(st_q);
          end
          st_d.length_enable      = len_bit;
          st_d.period_value[10:8] = wd[2:0];
          // Trigger
          if (wd[7]) begin
            st_d.enable_flag    = (st_d.env_start_volume != '0) || st_d.env_up;
            st_d.period_count   = reload_f(st_d.period_value);
            st_d.env_count      = (st_d.env_period != '0) ?
                                  {1'b0, st_d.env_period} : ENV_DEFAULT;
            st_d.current_volume = st_d.env_start_volume;
            if (st_d.length_count == '0) begin
              st_d.length_count = (item_i.frame_phase_odd && len_bit) ?
                                  LEN_FULL_M1 : LEN_FULL;
            end
          end
        end else begin
          st_d = st_q;
        end
      end
      OP_READ: begin
        priority if (item_i.address == ADDR_DUTY_LEN) begin
          rd = {st_q.duty_select, READ_LOW_SET};
        end else if (item_i.address == ADDR_ENVELOPE) begin
          rd = {st_q.env_start_volume, st_q.env_up, st_q.env_period};
        end else if (item_i.address == ADDR_FREQ_HI) begin
          rd = {1'b1, st_q.length_enable, READ_LOW_SET};
        end else begin
          rd = READ_OPEN;
        end
      end
      OP_POWER: begin
        st_d = '0;
        st_d.length_count = item_i.power_init_length ? LEN_FULL : st_q.length_count;
      end
      default: begin
        st_d = st_q;
      end
    endcase
  end

  // Result for this item, from the state it leaves
  always_comb begin
    res_o.sample_out = st_d.enable_flag ? st_d.last_sample : 4'd0;
    res_o.read_data  = rd;
    res_o.channel_on = st_d.enable_flag;
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv_i) begin
      st_q <= st_d;
    end
  end

endmodule

/* rtl/square_wave_sound_channel_core.sv */
// Square wave sound channel core: input register, channel update, result register.
// Output: each result is registered in the result register when its item leaves the input register.
// Throughput: one item per cycle unless result_o stalls; the input register, channel
// state update and result register form a two-stage path with no iteration.
// Reset: all channel state clears to zero and both stages empty.
// Depends on sqw_pkg, sqw_item_if, sqw_result_if and sqw_chan.
`timescale 1ns / 1ps
module square_wave_sound_channel_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  sqw_item_if.sink     item_i,
  sqw_result_if.source result_o
);
  import sqw_pkg::*;

  logic    in_v_q;
  item_t   in_q;
  logic    out_v_q;
  result_t out_q;
  result_t res;
  logic    adv;
  logic    in_ready;

  // Advance the input stage whenever the result register is free or draining
  assign adv      = in_v_q && (!out_v_q || result_o.ready);
  assign in_ready = !in_v_q || adv;
  assign item_i.ready = in_ready;

  // Hold the accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready) begin
      in_v_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && item_i.valid) begin
      in_q.opcode            <= op_e'(item_i.opcode);
      in_q.address           <= item_i.address;
      in_q.write_data        <= item_i.write_data;
      in_q.frame_phase_odd   <= item_i.frame_phase_odd;
      in_q.power_init_length <= item_i.power_init_length;
    end
  end

  sqw_chan u_chan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (in_q),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (result_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign result_o.valid      = out_v_q;
  assign result_o.sample_out = out_q.sample_out;
  assign result_o.read_data  = out_q.read_data;
  assign result_o.channel_on = out_q.channel_on;

`ifndef SYNTHESIS
  // A disabled channel is silent
  a_silent_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.channel_on || out_q.sample_out == 4'd0))
    else $error("sample nonzero while channel off");

  // Only a read item returns register data
  a_read_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.opcode != OP_READ) |=> (out_q.read_data == READ_OPEN))
    else $error("read data driven by a non-read item");

  // A blocked input stage keeps its item
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !adv) |=> (in_v_q && $stable(in_q)))
    else $error("input stage item lost while stalled");

  // An empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> item_i.ready)
    else $error("input stalled with empty result register");
`endif

endmodule
